>>> rtl/core/bgrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgrs_pkg: shared types and constants for the bus generation reset scheduler
// Status and command codes, register indexes, reset values and the
// generation sequence rule.
// ----------------------------------------------------------------------------
package bgrs_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int REG_W          = 31;
    localparam int GEN_W          = 4;
    localparam int NUM_GEN        = 16;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 3;
    localparam int CFG_IDX_W      = 2;

    localparam logic [GEN_W-1:0] GEN_FIRST = 4'd2;
    localparam logic [GEN_W-1:0] GEN_LAST  = 4'hf;

    localparam logic [REG_W-1:0] HOLDOFF_RST = 31'd60000;
    localparam logic [REG_W-1:0] SETTLE_RST  = 31'd1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_UPDATE = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOTHING    = 3'd0,
        ST_REJECTED   = 3'd1,
        ST_SCHEDULED  = 3'd2,
        ST_RESET      = 3'd3,
        ST_IMAGE_FAIL = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLDOFF = 2'd0,
        CFG_SETTLE  = 2'd1
    } t_cfg_idx;

    // Sequence 2..15 then back to 2; from 0 or 1 go to 2.
    function automatic logic [GEN_W-1:0] gen_successor(input logic [GEN_W-1:0] cur);
        logic [GEN_W-1:0] g;
        if (cur == GEN_LAST || cur < GEN_FIRST) begin
            g = GEN_FIRST;
        end else begin
            g = cur + 4'd1;
        end
        return g;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/bus_generation_reset_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bus_generation_reset_scheduler: delayed bus reset with generation holdoff
// Counts ticks, arms a one-shot deadline on a ROM update request and commits
// the next generation with a short bus reset when the deadline is reached with a good image.
// ----------------------------------------------------------------------------
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-------------------------------------
//  input   | i_in_valid  | o_in_ready  | i_command, i_image_ok
//  result  | o_out_valid | i_out_ready | o_status, o_generation_out, o_bus_reset
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One word per cycle while results are taken: the word is decoded and the
//  state updated in the accepting cycle, and the result shows in the next cycle.
//  The path is set by the stamp age compare and the deadline add.
//  Reset clears all but stamps and result payload at once; no clearing pass.
//  Input ready drops only while the result register holds a word not taken.
// ----------------------------------------------------------------------------
module bus_generation_reset_scheduler
    import bgrs_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire [CMD_W-1:0]      i_command,
    input  wire                  i_image_ok,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [GEN_W-1:0]     o_generation_out,
    output logic                 o_bus_reset,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [REG_W-1:0]      i_cfg_data
);

    localparam int CMP_W = (TIME_WIDTH > REG_W) ? TIME_WIDTH : REG_W;

    logic [REG_W-1:0]      r_holdoff, r_settle;
    logic [TIME_WIDTH-1:0] r_time,    n_time;
    logic [GEN_W-1:0]      r_cur_gen, n_cur_gen;
    logic                  r_rom_changed, n_rom_changed;
    logic                  r_armed,   n_armed;
    logic [TIME_WIDTH-1:0] r_deadline, n_deadline;
    logic [TIME_WIDTH-1:0] r_stamp [NUM_GEN];
    logic [NUM_GEN-1:0]    r_used,    n_used;
    logic                  n_stamp_we;

    logic                  r_out_valid;
    t_status               r_status,  n_status;
    logic [GEN_W-1:0]      r_gen_out;
    logic                  r_bus_reset, n_bus_reset;

    logic                  accept;
    logic [GEN_W-1:0]      gen_nxt;
    logic [TIME_WIDTH-1:0] time_inc;
    logic [TIME_WIDTH-1:0] stamp_nxt;
    logic [TIME_WIDTH-1:0] age;
    logic [CMP_W-1:0]      age_ext, hold_ext, settle_ext;
    logic [REG_W-1:0]      settle_eff;
    logic                  held;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    assign gen_nxt    = gen_successor(r_cur_gen);
    assign time_inc   = r_time + TIME_WIDTH'(1);
    assign stamp_nxt  = r_stamp[gen_nxt];
    assign age        = r_time - stamp_nxt;
    assign settle_eff = (r_settle == '0) ? REG_W'(1) : r_settle;
    assign age_ext    = CMP_W'(age);
    assign hold_ext   = CMP_W'(r_holdoff);
    assign settle_ext = CMP_W'(settle_eff);
    assign held       = r_used[gen_nxt] && (age_ext < hold_ext);

    always_comb begin
        n_time        = r_time;
        n_cur_gen     = r_cur_gen;
        n_rom_changed = r_rom_changed;
        n_armed       = r_armed;
        n_deadline    = r_deadline;
        n_used        = r_used;
        n_stamp_we    = 1'b0;
        n_status      = ST_NOTHING;
        n_bus_reset   = 1'b0;
        case (t_cmd'(i_command))
            CMD_TICK: begin
                n_time = time_inc;
                if (r_armed && time_inc == r_deadline) begin
                    n_armed = 1'b0;
                    if (i_image_ok) begin
                        n_cur_gen       = gen_nxt;
                        n_rom_changed   = 1'b0;
                        n_used[gen_nxt] = 1'b1;
                        n_stamp_we      = 1'b1;
                        n_status        = ST_RESET;
                        n_bus_reset     = 1'b1;
                    end else begin
                        n_status = ST_IMAGE_FAIL;
                    end
                end
            end
            CMD_MARK: begin
                n_rom_changed = 1'b1;
            end
            CMD_UPDATE: begin
                if (!r_rom_changed) begin
                    n_status = ST_REJECTED;
                end else begin
                    // Wait out the holdoff of the next generation if it applies.
                    if (held) begin
                        n_deadline = stamp_nxt + hold_ext[TIME_WIDTH-1:0];
                    end else begin
                        n_deadline = r_time + settle_ext[TIME_WIDTH-1:0];
                    end
                    n_armed  = 1'b1;
                    n_status = ST_SCHEDULED;
                end
            end
            default: begin
                n_status = ST_NOTHING;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff     <= HOLDOFF_RST;
            r_settle      <= SETTLE_RST;
            r_time        <= '0;
            r_cur_gen     <= '0;
            r_rom_changed <= 1'b0;
            r_armed       <= 1'b0;
            r_deadline    <= '0;
            r_used        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_HOLDOFF: r_holdoff <= i_cfg_data;
                    CFG_SETTLE:  r_settle  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_time        <= n_time;
                r_cur_gen     <= n_cur_gen;
                r_rom_changed <= n_rom_changed;
                r_armed       <= n_armed;
                r_deadline    <= n_deadline;
                r_used        <= n_used;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stamps are read only where the used bit is set.
    always_ff @(posedge i_clk) begin
        if (accept && n_stamp_we) begin
            r_stamp[gen_nxt] <= time_inc;
        end
    end

    // Result register: payload loads with each accepted word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_gen_out   <= n_cur_gen;
            r_bus_reset <= n_bus_reset;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_generation_out = r_gen_out;
    assign o_bus_reset      = r_bus_reset;

endmodule
`default_nettype wire

>>> rtl/core/bgrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgrs_checker: port-level checks for the bus generation reset scheduler
// Watches the result channel and the reset behavior.
// ----------------------------------------------------------------------------
module bgrs_checker
    import bgrs_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input wire [STATUS_W-1:0]  o_status,
    input wire [GEN_W-1:0]     o_generation_out,
    input wire                 o_bus_reset
);

    // A bus reset comes only with the reset-issued status, and always with it.
    a_reset_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bus_reset == (o_status == ST_RESET)))
        else $error("bus_reset and status disagree");

    // A committed generation lies in 2..15.
    a_gen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bus_reset) |-> (o_generation_out >= GEN_FIRST))
        else $error("committed generation out of range");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_IMAGE_FAIL))
        else $error("undefined status code");

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_generation_out) && $stable(o_bus_reset)))
        else $error("stalled result word changed");

    // An accepted word always yields a result word next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted word produced no result");

endmodule

bind bus_generation_reset_scheduler bgrs_checker u_bgrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_generation_out (o_generation_out),
    .o_bus_reset      (o_bus_reset)
);
`default_nettype wire

>>> dv/tb_bus_generation_reset_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bus_generation_reset_scheduler: self-checking bench for the scheduler
// Sends ticks, change marks and update requests with random gaps and
// result backpressure. The bench tracks its own copy of the time base,
// generation stamps and deadline, and checks every status word field by field.
// ----------------------------------------------------------------------------
module tb_bus_generation_reset_scheduler;
    import bgrs_pkg::*;

    localparam int TW           = TIME_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 700;
    localparam int MAX_GAP      = 6;
    localparam int MAX_FIRE_WAIT = 150;

    localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

    typedef struct packed {
        t_status          status;
        logic [GEN_W-1:0] gen;
        logic             bus_reset;
    } t_sched_word;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     in_command;
    logic                 in_image;
    logic                 out_valid;
    logic                 out_ready;
    logic [STATUS_W-1:0]  out_status;
    logic [GEN_W-1:0]     out_gen;
    logic                 out_bus_reset;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    // scheduler state as the bench sees it
    logic [TW-1:0]        now_ticks;
    logic [GEN_W-1:0]     gen_q;
    logic                 rom_dirty;
    logic                 fire_armed;
    logic [TW-1:0]        fire_at;
    logic [TW-1:0]        commit_stamp [NUM_GEN];
    logic                 commit_seen  [NUM_GEN];
    logic [REG_W-1:0]     holdoff_reg;
    logic [REG_W-1:0]     settle_reg;

    t_sched_word          expected_q [$];

    logic                 burst;
    int                   out_hold;
    int                   cycles;
    int                   mismatches;
    int                   results_checked;
    int                   words_sent;
    int                   live_words;
    int                   resets_seen;
    int                   image_fails;
    int                   holdoffs_taken;

    bus_generation_reset_scheduler dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_command        (in_command),
        .i_image_ok       (in_image),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (out_status),
        .o_generation_out (out_gen),
        .o_bus_reset      (out_bus_reset),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [GEN_W-1:0] following_gen(input logic [GEN_W-1:0] g);
        logic [GEN_W:0] sum;
        sum = {1'b0, g} + 1'b1;
        if (sum > {1'b0, GEN_LAST} || sum < {1'b0, GEN_FIRST}) begin
            return GEN_FIRST;
        end
        return sum[GEN_W-1:0];
    endfunction

    // Advance the tracked state by one accepted word and form its result.
    task automatic predict_word(input logic [CMD_W-1:0] cmd, input logic img,
                                output t_sched_word w);
        logic [GEN_W-1:0] ng;
        logic [TW-1:0]    settle_eff;
        w.status    = ST_NOTHING;
        w.bus_reset = 1'b0;
        case (cmd)
            CMD_TICK: begin
                now_ticks = now_ticks + 1'b1;
                if (fire_armed && now_ticks == fire_at) begin
                    fire_armed = 1'b0;
                    if (img) begin
                        ng                = following_gen(gen_q);
                        gen_q             = ng;
                        rom_dirty         = 1'b0;
                        commit_stamp[ng]  = now_ticks;
                        commit_seen[ng]   = 1'b1;
                        w.status          = ST_RESET;
                        w.bus_reset       = 1'b1;
                        resets_seen++;
                    end else begin
                        w.status = ST_IMAGE_FAIL;
                        image_fails++;
                    end
                end
            end
            CMD_MARK: begin
                rom_dirty = 1'b1;
            end
            CMD_UPDATE: begin
                if (!rom_dirty) begin
                    w.status = ST_REJECTED;
                end else begin
                    ng         = following_gen(gen_q);
                    settle_eff = (settle_reg == '0) ? TW'(1) : TW'(settle_reg);
                    // a recently committed generation waits out its holdoff
                    if (commit_seen[ng] &&
                        (now_ticks - commit_stamp[ng]) < TW'(holdoff_reg)) begin
                        fire_at = commit_stamp[ng] + TW'(holdoff_reg);
                        holdoffs_taken++;
                    end else begin
                        fire_at = now_ticks + settle_eff;
                    end
                    fire_armed = 1'b1;
                    w.status   = ST_SCHEDULED;
                end
            end
            default: begin
            end
        endcase
        w.gen = gen_q;
    endtask

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic img);
        int          gap;
        t_sched_word w;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid   = 1'b1;
        in_command = cmd;
        in_image   = img;
        do @(posedge clk); while (!in_ready);
        predict_word(cmd, img, w);
        expected_q.push_back(w);
        words_sent++;
        if (cmd != CMD_UNDEF) begin
            live_words++;
        end
    endtask

    // Drop valid and hold until every pending result is taken.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [REG_W-1:0] val);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_HOLDOFF) begin
            holdoff_reg = val;
        end else begin
            settle_reg = val;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic tick_until_fired(input logic img);
        while (fire_armed) begin
            send_word(CMD_TICK, img);
        end
    endtask

    task automatic commit_once();
        send_word(CMD_MARK, 1'b0);
        send_word(CMD_UPDATE, 1'b0);
        tick_until_fired(1'b1);
    endtask

    task automatic test_reset_defaults();
        burst = 1'b1;
        send_word(CMD_UPDATE, 1'b1);    // nothing marked yet
        send_word(CMD_UNDEF, 1'b1);
        send_word(CMD_TICK, 1'b0);
        send_word(CMD_MARK, 1'b0);
        send_word(CMD_UPDATE, 1'b0);    // default settle delay arms a far deadline
        repeat (20) send_word(CMD_TICK, 1'b1);
        burst = 1'b0;
    endtask

    task automatic test_commands();
        write_reg(CFG_SETTLE, '0);
        write_reg(CFG_HOLDOFF, '0);
        send_word(CMD_UPDATE, 1'b1);    // replace the far deadline with one tick
        send_word(CMD_TICK, 1'b1);      // commit
        send_word(CMD_UPDATE, 1'b0);    // rom clean again after commit
        send_word(CMD_MARK, 1'b0);
        send_word(CMD_MARK, 1'b1);
        send_word(CMD_UPDATE, 1'b1);    // zero settle acts as one tick
        send_word(CMD_TICK, 1'b0);      // deadline hit, image build fails
        send_word(CMD_TICK, 1'b1);      // disarmed
        send_word(CMD_UPDATE, 1'b0);    // still marked: schedule again
        send_word(CMD_UPDATE, 1'b1);    // replace the deadline
        send_word(CMD_UNDEF, 1'b0);
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_UNDEF, 1'b1);
    endtask

    task automatic test_generation_holdoff();
        write_reg(CFG_HOLDOFF, 31'd40);
        write_reg(CFG_SETTLE, 31'd1);
        // over two laps through 2..15 so reuse falls inside the holdoff window
        repeat (30) commit_once();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_HOLDOFF, '1);
        write_reg(CFG_SETTLE, '1);
        send_word(CMD_MARK, 1'b1);
        send_word(CMD_UPDATE, 1'b1);    // far deadline, never reached here
        repeat (4) send_word(CMD_TICK, 1'b1);
        write_reg(CFG_HOLDOFF, '0);
        write_reg(CFG_SETTLE, 31'd5);
        send_word(CMD_UPDATE, 1'b0);
        tick_until_fired(1'b1);
        write_reg(CFG_HOLDOFF, 31'd1);
        write_reg(CFG_SETTLE, '1);
        send_word(CMD_MARK, 1'b0);
        send_word(CMD_UPDATE, 1'b0);
        repeat (3) send_word(CMD_TICK, 1'b0);
        write_reg(CFG_SETTLE, 31'd2);
        send_word(CMD_UPDATE, 1'b1);
        tick_until_fired(1'b1);
        send_word(CMD_UPDATE, 1'b1);
    endtask

    task automatic send_noise();
        logic [CMD_W-1:0] c;
        c = CMD_W'($urandom_range(CMD_TICK, CMD_UNDEF));
        send_word(c, 1'($urandom));
    endtask

    task automatic test_random();
        int quota;
        int phase;
        int n;
        for (phase = 0; phase < 4; phase++) begin
            if (phase == 0) begin
                write_reg(CFG_HOLDOFF, 31'd1);
                write_reg(CFG_SETTLE, 31'd1);
            end else begin
                write_reg(CFG_HOLDOFF, REG_W'($urandom_range(0, 80)));
                write_reg(CFG_SETTLE, REG_W'($urandom_range(0, 10)));
            end
            quota = live_words + RANDOM_ITEMS / 4;
            while (live_words < quota) begin
                if ($urandom_range(0, 7) == 0) begin
                    burst = ~burst;
                end
                if ($urandom_range(0, 3) != 0) begin
                    if ($urandom_range(0, 9) != 0) begin
                        send_word(CMD_MARK, 1'($urandom));
                    end
                    send_word(CMD_UPDATE, 1'($urandom));
                    n = 0;
                    while (fire_armed && n < MAX_FIRE_WAIT) begin
                        if ($urandom_range(0, 19) == 0) begin
                            send_noise();
                        end else begin
                            send_word(CMD_TICK, $urandom_range(0, 7) != 0);
                        end
                        n++;
                    end
                end else begin
                    repeat ($urandom_range(1, 6)) send_noise();
                end
            end
            burst = 1'b0;
        end
    endtask

    // result side: drop ready for a random stall after each taken word (none in burst mode)
    always @(negedge clk) begin
        if (out_hold > 0) begin
            out_ready = 1'b0;
            out_hold--;
        end else begin
            out_ready = 1'b1;
        end
    end

    always @(posedge clk) begin : check_results
        t_sched_word w;
        if (rst_n && out_valid && out_ready) begin
            out_hold = burst ? 0 : $urandom_range(0, MAX_GAP);
            results_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] unexpected word: status=%0d gen=%0d reset=%0b",
                             $time, out_status, out_gen, out_bus_reset);
                end
            end else begin
                w = expected_q.pop_front();
                if (out_status !== w.status || out_gen !== w.gen ||
                    out_bus_reset !== w.bus_reset) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] word %0d: expected status=%0d gen=%0d reset=%0b",
                                 $time, results_checked, w.status, w.gen, w.bus_reset);
                        $display("[%0t] word %0d:      got status=%0d gen=%0d reset=%0b",
                                 $time, results_checked, out_status, out_gen,
                                 out_bus_reset);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("cycle limit hit with %0d words outstanding", expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_command      = CMD_TICK;
        in_image        = 1'b0;
        out_ready       = 1'b1;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_HOLDOFF;
        cfg_data        = '0;
        burst           = 1'b0;
        out_hold        = 0;
        cycles          = 0;
        mismatches      = 0;
        results_checked = 0;
        words_sent      = 0;
        live_words      = 0;
        resets_seen     = 0;
        image_fails     = 0;
        holdoffs_taken  = 0;
        now_ticks       = '0;
        gen_q           = '0;
        rom_dirty       = 1'b0;
        fire_armed      = 1'b0;
        fire_at         = '0;
        holdoff_reg     = HOLDOFF_RST;
        settle_reg      = SETTLE_RST;
        for (int i = 0; i < NUM_GEN; i++) begin
            commit_stamp[i] = '0;
            commit_seen[i]  = 1'b0;
        end
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_commands();
        test_generation_holdoff();
        test_register_extremes();
        test_random();

        wait_idle();
        $display("sent %0d words: %0d bus resets, %0d image failures, %0d holdoff deadlines",
                 words_sent, resets_seen, image_fails, holdoffs_taken);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
